// File: design/tpiw_pkg.sv
// Shared types and constants for the trilinear probe index and weight block.
package tpiw_pkg;

  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;
  localparam int FIFO_DEPTH   = 4;
  localparam int PTR_W        = 2;
  localparam int CNT_W        = 3;
  localparam int ENTRY_BASE_W = 207;

  typedef enum logic [2:0] {
    REG_GRID_VALID    = 3'd0,
    REG_ORIGIN_X      = 3'd1,
    REG_ORIGIN_Y      = 3'd2,
    REG_ORIGIN_Z      = 3'd3,
    REG_INV_SPACING_X = 3'd4,
    REG_INV_SPACING_Y = 3'd5,
    REG_INV_SPACING_Z = 3'd6,
    REG_GRID_DIMS     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [2:0]  corner;
    logic [29:0] probe_index;
    logic [24:0] weight;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic               grid_valid;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] origin_z;
    logic [23:0]        inv_spacing_x;
    logic [23:0]        inv_spacing_y;
    logic [23:0]        inv_spacing_z;
    logic [29:0]        grid_dims;
  } cfg_t;

endpackage

// File: design/tpiw_regs.sv
// Configuration register file with APB-style access.
module tpiw_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tpiw_pkg::ADDR_W-1:0] paddr,
  input  logic [tpiw_pkg::DATA_W-1:0] pwdata,
  output logic [tpiw_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tpiw_pkg::cfg_t             cfg
);
  import tpiw_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.grid_valid    <= 1'b0;
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.origin_z      <= '0;
      cfg_r.inv_spacing_x <= 24'd65536;
      cfg_r.inv_spacing_y <= 24'd65536;
      cfg_r.inv_spacing_z <= 24'd65536;
      cfg_r.grid_dims     <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_GRID_VALID:    cfg_r.grid_valid    <= pwdata[0];
        REG_ORIGIN_X:      cfg_r.origin_x      <= pwdata[23:0];
        REG_ORIGIN_Y:      cfg_r.origin_y      <= pwdata[23:0];
        REG_ORIGIN_Z:      cfg_r.origin_z      <= pwdata[23:0];
        REG_INV_SPACING_X: cfg_r.inv_spacing_x <= pwdata[23:0];
        REG_INV_SPACING_Y: cfg_r.inv_spacing_y <= pwdata[23:0];
        REG_INV_SPACING_Z: cfg_r.inv_spacing_z <= pwdata[23:0];
        REG_GRID_DIMS:     cfg_r.grid_dims     <= pwdata[29:0];
        default:           cfg_r.grid_dims     <= cfg_r.grid_dims;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_GRID_VALID:    prdata = {31'd0, cfg_r.grid_valid};
      REG_ORIGIN_X:      prdata = {8'd0, cfg_r.origin_x};
      REG_ORIGIN_Y:      prdata = {8'd0, cfg_r.origin_y};
      REG_ORIGIN_Z:      prdata = {8'd0, cfg_r.origin_z};
      REG_INV_SPACING_X: prdata = {8'd0, cfg_r.inv_spacing_x};
      REG_INV_SPACING_Y: prdata = {8'd0, cfg_r.inv_spacing_y};
      REG_INV_SPACING_Z: prdata = {8'd0, cfg_r.inv_spacing_z};
      REG_GRID_DIMS:     prdata = {2'd0, cfg_r.grid_dims};
      default:           prdata = '0;
    endcase
  end

endmodule

// File: design/tpiw_front.sv
// Front end: accepts queries, computes grid cells, fractions and partial terms.
module tpiw_front #(
  parameter int DIM_BITS = 10,
  parameter int ENTRY_W  = 227
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  tpiw_pkg::in_item_t   in_item,
  input  tpiw_pkg::cfg_t       cfg,
  input  logic                 pop,
  output logic                 push,
  output logic [ENTRY_W-1:0]   push_data
);
  import tpiw_pkg::*;

  localparam int EXT_W = 30 + 3 * DIM_BITS;
  localparam int NP_W  = (2 * DIM_BITS + 2 > 30) ? 2 * DIM_BITS + 2 : 30;
  localparam int YP_W  = (2 * DIM_BITS + 1 > 30) ? 2 * DIM_BITS + 1 : 30;
  localparam int ZP_W  = DIM_BITS + 30;

  typedef struct packed {
    logic                     ok;
    logic [29:0]              zt0;
    logic [29:0]              zt1;
    logic [29:0]              yt0;
    logic [29:0]              yt1;
    logic [DIM_BITS-1:0]      cx0;
    logic [DIM_BITS-1:0]      cx1;
    logic [3:0][16:0]         wxy;
    logic [8:0]               wz0;
    logic [8:0]               wz1;
  } entry_t;

  logic               accept;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               v0_r, v1_r, v2_r, v3_r;

  logic [23:0]        pos   [3];
  logic [23:0]        org   [3];
  logic [23:0]        inv   [3];
  logic [24:0]        diff  [3];
  logic [DIM_BITS-1:0] maxi [3];
  logic [EXT_W-1:0]   dims_ext;

  logic               ok0_r, ok1_r, ok2_r;
  logic [23:0]        d0_r  [3];
  logic [47:0]        p1_r  [3];
  logic [DIM_BITS-1:0] c0_nxt [3];
  logic [DIM_BITS-1:0] c1_nxt [3];
  logic [DIM_BITS-1:0] c0_r [3];
  logic [DIM_BITS-1:0] c1_r [3];
  logic [8:0]         w0_r  [3];
  logic [8:0]         w1_r  [3];

  logic [DIM_BITS:0]  nx, ny;
  logic [DIM_BITS:0]  nx_r;
  logic [NP_W-1:0]    nxy_full;
  logic [29:0]        nxy_r;
  logic [ZP_W-1:0]    zprod0, zprod1;
  logic [YP_W-1:0]    yprod0, yprod1;
  logic [17:0]        wprod [4];
  entry_t             ent_nxt, ent3_r;

  assign accept = start & ~busy;
  assign busy   = (cnt_r == CNT_W'(FIFO_DEPTH));

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      v0_r  <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      v0_r  <= accept;
      v1_r  <= v0_r;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
    end
  end

  assign pos[0] = in_item.pos_x;
  assign pos[1] = in_item.pos_y;
  assign pos[2] = in_item.pos_z;
  assign org[0] = cfg.origin_x;
  assign org[1] = cfg.origin_y;
  assign org[2] = cfg.origin_z;
  assign inv[0] = cfg.inv_spacing_x;
  assign inv[1] = cfg.inv_spacing_y;
  assign inv[2] = cfg.inv_spacing_z;
  assign dims_ext = {{(3 * DIM_BITS){1'b0}}, cfg.grid_dims};

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {pos[a][23], pos[a]} - {org[a][23], org[a]};
      maxi[a] = dims_ext[a * DIM_BITS +: DIM_BITS];
      if (p1_r[a][47:24] > {{(24 - DIM_BITS){1'b0}}, maxi[a]}) begin
        c0_nxt[a] = maxi[a];
      end else begin
        c0_nxt[a] = p1_r[a][24 +: DIM_BITS];
      end
      if (c0_nxt[a] == maxi[a]) begin
        c1_nxt[a] = maxi[a];
      end else begin
        c1_nxt[a] = c0_nxt[a] + {{(DIM_BITS - 1){1'b0}}, 1'b1};
      end
    end
  end

  // Stages 0..2: clamped difference, scaled coordinate, cell and weight factors.
  always_ff @(posedge clk) begin
    ok0_r <= cfg.grid_valid;
    ok1_r <= ok0_r;
    ok2_r <= ok1_r;
    for (int a = 0; a < 3; a++) begin
      d0_r[a] <= diff[a][24] ? 24'd0 : diff[a][23:0];
      p1_r[a] <= {24'd0, d0_r[a]} * {24'd0, inv[a]};
      c0_r[a] <= c0_nxt[a];
      c1_r[a] <= c1_nxt[a];
      w1_r[a] <= {1'b0, p1_r[a][23:16]};
      w0_r[a] <= 9'd256 - {1'b0, p1_r[a][23:16]};
    end
  end

  assign nx       = {1'b0, maxi[0]} + {{DIM_BITS{1'b0}}, 1'b1};
  assign ny       = {1'b0, maxi[1]} + {{DIM_BITS{1'b0}}, 1'b1};
  assign nxy_full = NP_W'(nx) * NP_W'(ny);

  always_ff @(posedge clk) begin
    nx_r  <= nx;
    nxy_r <= nxy_full[29:0];
  end

  assign zprod0 = ZP_W'(c0_r[2]) * ZP_W'(nxy_r);
  assign zprod1 = ZP_W'(c1_r[2]) * ZP_W'(nxy_r);
  assign yprod0 = YP_W'(c0_r[1]) * YP_W'(nx_r);
  assign yprod1 = YP_W'(c1_r[1]) * YP_W'(nx_r);

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      wprod[k] = {9'd0, (k[0] ? w1_r[0] : w0_r[0])} * {9'd0, (k[1] ? w1_r[1] : w0_r[1])};
    end
    ent_nxt.ok  = ok2_r;
    ent_nxt.zt0 = zprod0[29:0];
    ent_nxt.zt1 = zprod1[29:0];
    ent_nxt.yt0 = yprod0[29:0];
    ent_nxt.yt1 = yprod1[29:0];
    ent_nxt.cx0 = c0_r[0];
    ent_nxt.cx1 = c1_r[0];
    for (int k = 0; k < 4; k++) begin
      ent_nxt.wxy[k] = wprod[k][16:0];
    end
    ent_nxt.wz0 = w0_r[2];
    ent_nxt.wz1 = w1_r[2];
  end

  always_ff @(posedge clk) begin
    ent3_r <= ent_nxt;
  end

  assign push      = v3_r;
  assign push_data = ent3_r;

  a_push_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != '0)
    else $error("front: item pushed without a reserved queue slot");

endmodule

// File: design/tpiw_queue.sv
// Small register queue between front and back ends.
module tpiw_queue #(
  parameter int WIDTH = 227
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty
);
  import tpiw_pkg::*;

  logic [WIDTH-1:0] mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != CNT_W'(FIFO_DEPTH)) || pop)
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue: pop while empty");

endmodule

// File: design/tpiw_back.sv
// Back end: steps through the eight corners of each valid queued item; a failed item gives one result.
module tpiw_back #(
  parameter int DIM_BITS = 10,
  parameter int ENTRY_W  = 227
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [ENTRY_W-1:0]    head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  output tpiw_pkg::out_item_t   out_item
);
  import tpiw_pkg::*;

  typedef struct packed {
    logic                     ok;
    logic [29:0]              zt0;
    logic [29:0]              zt1;
    logic [29:0]              yt0;
    logic [29:0]              yt1;
    logic [DIM_BITS-1:0]      cx0;
    logic [DIM_BITS-1:0]      cx1;
    logic [3:0][16:0]         wxy;
    logic [8:0]               wz0;
    logic [8:0]               wz1;
  } entry_t;

  entry_t      cur_r;
  logic        active_r;
  logic [2:0]  corner_r;
  logic        done;
  logic        bx, by, bz;
  logic [29:0] zt, yt, cx;
  logic [25:0] wprod;
  out_item_t   res_nxt, out_item_r;
  logic        out_valid_r;

  assign done = active_r && (!cur_r.ok || corner_r == 3'd7);
  assign pop  = !empty && (!active_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      corner_r <= '0;
    end else if (pop) begin
      active_r <= 1'b1;
      corner_r <= '0;
    end else if (done) begin
      active_r <= 1'b0;
    end else if (active_r) begin
      corner_r <= corner_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head;
    end
  end

  assign bx = corner_r[0];
  assign by = corner_r[1];
  assign bz = corner_r[2];
  assign zt = bz ? cur_r.zt1 : cur_r.zt0;
  assign yt = by ? cur_r.yt1 : cur_r.yt0;
  assign cx = {{(30 - DIM_BITS){1'b0}}, (bx ? cur_r.cx1 : cur_r.cx0)};
  assign wprod = {9'd0, cur_r.wxy[{by, bx}]} * {17'd0, (bz ? cur_r.wz1 : cur_r.wz0)};

  always_comb begin
    res_nxt.ok          = cur_r.ok;
    res_nxt.last        = done;
    res_nxt.corner      = '0;
    res_nxt.probe_index = '0;
    res_nxt.weight      = '0;
    if (cur_r.ok) begin
      res_nxt.corner      = corner_r;
      res_nxt.probe_index = zt + yt + cx;
      res_nxt.weight      = wprod[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_item_r.ok && !out_item_r.last |=>
      out_valid_r && out_item_r.corner == $past(out_item_r.corner) + 3'd1)
    else $error("back: corner run broken");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_item_r.ok |-> out_item_r.last)
    else $error("back: failure result not marked last");

endmodule

// File: design/trilinear_probe_index_weights_core.sv
// Top level of the trilinear probe index and weight generator.
// Each accepted query produces eight results, one per clock, corners 0..7 in order
// with last on corner 7; with grid_valid clear it produces a single failure result.
// The result channel sets the sustained query rate; for failures the rate is set by
// the four slots held from acceptance until the corner sequencer takes the item.
// When the corner sequencer is free, a query passes the four front stages, a queue
// entry, the sequencer's item register and the output register. A four-stage front
// pipeline feeds a four-entry queue; busy rises when four queries are held between
// acceptance and the corner sequencer, so several queries may be taken while results
// stream out. Results are shown for one cycle on out_valid and cannot be held off.
module trilinear_probe_index_weights_core #(
  parameter int DIM_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tpiw_pkg::in_item_t          in_item,
  output logic                        out_valid,
  output tpiw_pkg::out_item_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tpiw_pkg::ADDR_W-1:0] paddr,
  input  logic [tpiw_pkg::DATA_W-1:0] pwdata,
  output logic [tpiw_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import tpiw_pkg::*;

  localparam int ENTRY_W = ENTRY_BASE_W + 2 * DIM_BITS;

  cfg_t               cfg;
  logic               push, pop, empty;
  logic [ENTRY_W-1:0] push_data, head;

  tpiw_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tpiw_front #(
    .DIM_BITS (DIM_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg       (cfg),
    .pop       (pop),
    .push      (push),
    .push_data (push_data)
  );

  tpiw_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  tpiw_back #(
    .DIM_BITS (DIM_BITS),
    .ENTRY_W  (ENTRY_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: test/tpiw_corner_checker.sv
// Checker for the trilinear probe core: tracks register writes, predicts corner results, compares.
module tpiw_corner_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  tpiw_pkg::in_item_t          in_item,
  input  logic                        out_valid,
  input  tpiw_pkg::out_item_t         out_item,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tpiw_pkg::ADDR_W-1:0] paddr,
  input  logic [tpiw_pkg::DATA_W-1:0] pwdata,
  output int                          fail_count,
  output int                          pending
);
  import tpiw_pkg::*;

  localparam int REPORT_LIMIT = 10;

  cfg_t      grid_cfg;
  out_item_t expected_corners[$];

  function automatic void locate_axis(input logic signed [23:0] pos,
                                      input logic signed [23:0] org,
                                      input logic [23:0] inv,
                                      input logic [9:0] lim,
                                      output logic [9:0] lo,
                                      output logic [9:0] hi,
                                      output logic [7:0] frac);
    logic signed [25:0] diff;
    logic [25:0]        mag;
    logic [63:0]        prod;
    logic [63:0]        cell_idx;
    diff = pos - org;
    prod = '0;
    if (diff > 0) begin
      mag  = diff;
      prod = mag * inv;
    end
    cell_idx = prod >> 24;
    frac = prod[23:16];
    if (cell_idx > lim) begin
      cell_idx = lim;
    end
    lo = cell_idx[9:0];
    hi = (cell_idx + 1 > lim) ? lim : cell_idx[9:0] + 10'd1;
  endfunction

  function automatic void predict_corners(in_item_t q);
    logic [9:0]      lim[3];
    logic [9:0]      lo[3];
    logic [9:0]      hi[3];
    logic [7:0]      frac[3];
    longint unsigned nx, nxy, idx, wgt, cx, cy, cz, wx, wy, wz;
    out_item_t       r;
    int              k;
    r = '0;
    if (!grid_cfg.grid_valid) begin
      r.last = 1'b1;
      expected_corners.push_back(r);
      return;
    end
    lim[0] = grid_cfg.grid_dims[9:0];
    lim[1] = grid_cfg.grid_dims[19:10];
    lim[2] = grid_cfg.grid_dims[29:20];
    locate_axis(q.pos_x, grid_cfg.origin_x, grid_cfg.inv_spacing_x, lim[0],
                lo[0], hi[0], frac[0]);
    locate_axis(q.pos_y, grid_cfg.origin_y, grid_cfg.inv_spacing_y, lim[1],
                lo[1], hi[1], frac[1]);
    locate_axis(q.pos_z, grid_cfg.origin_z, grid_cfg.inv_spacing_z, lim[2],
                lo[2], hi[2], frac[2]);
    nx  = 64'(lim[0]) + 64'd1;
    nxy = nx * (64'(lim[1]) + 64'd1);
    for (k = 0; k < 8; k++) begin
      cx  = k[0] ? 64'(hi[0]) : 64'(lo[0]);
      cy  = k[1] ? 64'(hi[1]) : 64'(lo[1]);
      cz  = k[2] ? 64'(hi[2]) : 64'(lo[2]);
      wx  = k[0] ? 64'(frac[0]) : 64'd256 - 64'(frac[0]);
      wy  = k[1] ? 64'(frac[1]) : 64'd256 - 64'(frac[1]);
      wz  = k[2] ? 64'(frac[2]) : 64'd256 - 64'(frac[2]);
      idx = cz * nxy + cy * nx + cx;
      wgt = wx * wy * wz;
      r.ok          = 1'b1;
      r.corner      = k[2:0];
      r.probe_index = idx[29:0];
      r.weight      = wgt[24:0];
      r.last        = (k == 7);
      expected_corners.push_back(r);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      grid_cfg <= '{grid_valid: 1'b0, origin_x: '0, origin_y: '0, origin_z: '0,
                    inv_spacing_x: 24'h010000, inv_spacing_y: 24'h010000,
                    inv_spacing_z: 24'h010000, grid_dims: '0};
      expected_corners.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (out_valid) begin
        if (expected_corners.size() == 0) begin
          errs = 1;
          if (fail_count < REPORT_LIMIT) begin
            $display("unexpected result: ok=%0d corner=%0d index=%0d weight=%0d last=%0d",
                     out_item.ok, out_item.corner, out_item.probe_index,
                     out_item.weight, out_item.last);
          end
        end else begin
          exp_item = expected_corners.pop_front();
          if (exp_item.ok != out_item.ok || exp_item.corner != out_item.corner ||
              exp_item.probe_index != out_item.probe_index ||
              exp_item.weight != out_item.weight || exp_item.last != out_item.last) begin
            errs = 1;
            if (fail_count < REPORT_LIMIT) begin
              $display("mismatch: expected ok=%0d corner=%0d index=%0d weight=%0d last=%0d",
                       exp_item.ok, exp_item.corner, exp_item.probe_index,
                       exp_item.weight, exp_item.last);
              $display("          got      ok=%0d corner=%0d index=%0d weight=%0d last=%0d",
                       out_item.ok, out_item.corner, out_item.probe_index,
                       out_item.weight, out_item.last);
            end
          end
        end
      end
      if (start && !busy) begin
        predict_corners(in_item);
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_e'(paddr[4:2]))
          REG_GRID_VALID:    grid_cfg.grid_valid    <= pwdata[0];
          REG_ORIGIN_X:      grid_cfg.origin_x      <= pwdata[23:0];
          REG_ORIGIN_Y:      grid_cfg.origin_y      <= pwdata[23:0];
          REG_ORIGIN_Z:      grid_cfg.origin_z      <= pwdata[23:0];
          REG_INV_SPACING_X: grid_cfg.inv_spacing_x <= pwdata[23:0];
          REG_INV_SPACING_Y: grid_cfg.inv_spacing_y <= pwdata[23:0];
          REG_INV_SPACING_Z: grid_cfg.inv_spacing_z <= pwdata[23:0];
          REG_GRID_DIMS:     grid_cfg.grid_dims     <= pwdata[29:0];
          default: ;
        endcase
      end
      fail_count <= fail_count + errs;
      pending    <= expected_corners.size();
    end
  end

endmodule

// File: test/tb_trilinear_probe_index_weights_core.sv
// Testbench top for trilinear_probe_index_weights_core: clock, reset, stimulus and verdict.
module tb_trilinear_probe_index_weights_core;
  import tpiw_pkg::*;

  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_COUNT    = 9;
  localparam int ITEMS_PER_PHASE = 20;

  logic              clk     = 1'b0;
  logic              rst_n   = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_valid;
  out_item_t         out_item;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                stall_cycles = 0;

  logic [23:0] grid_origin[3];
  logic [23:0] grid_inv[3];
  logic [9:0]  grid_lim[3];

  trilinear_probe_index_weights_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  tpiw_corner_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_item   (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_trilinear_probe_index_weights_core failed");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] value, int width);
    logic [31:0] mask;
    logic [31:0] data;
    mask = (32'h1 << width) - 32'h1;
    data = value & mask;
    if ($urandom_range(0, 1) == 1) begin
      data = data | ($urandom & ~mask);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) begin
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  task automatic send_query(in_item_t q, int gap);
    logic taken;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= q;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
  endtask

  task automatic load_grid(logic valid, logic [23:0] org[3], logic [23:0] inv[3],
                           logic [29:0] dims);
    wait_drained();
    write_reg(REG_GRID_VALID, 32'(valid), 1);
    write_reg(REG_ORIGIN_X, 32'(org[0]), 24);
    write_reg(REG_ORIGIN_Y, 32'(org[1]), 24);
    write_reg(REG_ORIGIN_Z, 32'(org[2]), 24);
    write_reg(REG_INV_SPACING_X, 32'(inv[0]), 24);
    write_reg(REG_INV_SPACING_Y, 32'(inv[1]), 24);
    write_reg(REG_INV_SPACING_Z, 32'(inv[2]), 24);
    write_reg(REG_GRID_DIMS, 32'(dims), 30);
    grid_origin = org;
    grid_inv    = inv;
    grid_lim[0] = dims[9:0];
    grid_lim[1] = dims[19:10];
    grid_lim[2] = dims[29:20];
  endtask

  function automatic logic [23:0] pick_coord(int a);
    longint unsigned span;
    int              r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return 24'($urandom);
    end
    if (r < 30) begin
      return grid_origin[a] - 24'($urandom_range(1, 1024));
    end
    if (grid_inv[a] == 0) begin
      span = 64'h10000;
    end else begin
      span = ((64'(grid_lim[a]) + 64'd2) << 24) / grid_inv[a];
    end
    if (span > 64'hFFFFFF) begin
      span = 64'hFFFFFF;
    end
    return grid_origin[a] + 24'($urandom_range(0, 32'(span)));
  endfunction

  function automatic in_item_t make_query(logic [23:0] x, logic [23:0] y, logic [23:0] z);
    in_item_t q;
    q.pos_x = x;
    q.pos_y = y;
    q.pos_z = z;
    return q;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 40);
  endfunction

  task automatic setup_phase(int p);
    logic [23:0] org[3];
    logic [23:0] inv[3];
    logic [9:0]  lim[3];
    logic        valid;
    int          a;
    valid = 1'b1;
    for (a = 0; a < 3; a++) begin
      org[a] = ($urandom_range(0, 1) == 1) ? 24'($urandom)
                                           : 24'($urandom_range(0, 8192)) - 24'd4096;
      inv[a] = ($urandom_range(0, 9) == 0) ? 24'($urandom)
                                           : 24'($urandom_range(24'h004000, 24'h040000));
      lim[a] = ($urandom_range(0, 6) == 0) ? 10'($urandom_range(0, 1023))
                                           : 10'($urandom_range(0, 12));
    end
    case (p)
      0: valid = 1'b0;
      1: begin
        org = '{24'h800000, 24'h800000, 24'h800000};
        inv = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF};
        lim = '{10'h3FF, 10'h3FF, 10'h3FF};
      end
      2: begin
        org = '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
        inv = '{24'h000000, 24'h000000, 24'h000000};
        lim = '{10'h000, 10'h000, 10'h000};
      end
      3: begin
        org = '{24'h000000, 24'h000000, 24'h000000};
        inv = '{24'h010000, 24'h010000, 24'h010000};
      end
      default: ;
    endcase
    load_grid(valid, org, inv, {lim[2], lim[1], lim[0]});
  endtask

  initial begin
    int p;
    int i;
    int gap;
    grid_origin = '{24'h000000, 24'h000000, 24'h000000};
    grid_inv    = '{24'h010000, 24'h010000, 24'h010000};
    grid_lim    = '{10'd3, 10'd2, 10'd1};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no grid loaded yet
    send_query(make_query(24'h7FFFFF, 24'h800000, 24'h000000), 0);
    send_query(make_query(24'h800000, 24'h7FFFFF, 24'hFFFFFF), 0);

    // reset origin and spacing, 4x3x2 grid
    wait_drained();
    write_reg(REG_GRID_VALID, 32'd1, 1);
    write_reg(REG_GRID_DIMS, 32'h0010_0803, 30);
    send_query(make_query(24'h000000, 24'h000000, 24'h000000), 0);
    send_query(make_query(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF), 0);
    send_query(make_query(24'h800000, 24'h800000, 24'h800000), 0);
    send_query(make_query(24'h000080, 24'h000040, 24'h0000C0), 0);
    send_query(make_query(24'h000180, 24'h0002FF, 24'h0001FF), 0);
    send_query(make_query(24'h000300, 24'h000200, 24'h000100), 1);
    send_query(make_query(24'h0003FF, 24'h0002FF, 24'h0001FF), 0);
    send_query(make_query(24'h555555, 24'hAAAAAA, 24'h000001), 2);
    send_query(make_query(24'hFFFFFF, 24'h0000FF, 24'h010080), 0);
    send_query(make_query(24'h0001FF, 24'h800001, 24'h0000FF), 0);

    for (p = 0; p < PHASE_COUNT; p++) begin
      setup_phase(p);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        gap = (p == 3) ? 0 : pick_gap();
        if (p != 3 && $urandom_range(0, 19) == 0) begin
          wait_drained();
        end
        send_query(make_query(pick_coord(0), pick_coord(1), pick_coord(2)), gap);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_trilinear_probe_index_weights_core passed");
    end else begin
      $display("tb_trilinear_probe_index_weights_core failed");
    end
    $finish;
  end

endmodule
